### rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, register indexes, reset values and step codes for the
// accelerometer step detector.
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned KIND_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD_SQ  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD_SQ = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_INTERVAL      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT        = CFG_IDX_W'(3);

  localparam logic [WORD_W-1:0] RST_LOW_THRESHOLD_SQ  = WORD_W'(585693);
  localparam logic [WORD_W-1:0] RST_HIGH_THRESHOLD_SQ = WORD_W'(683152);
  localparam logic [WORD_W-1:0] RST_RUN_INTERVAL      = WORD_W'(110);
  localparam logic [WORD_W-1:0] RST_IDLE_LIMIT        = WORD_W'(30000);

  typedef logic [KIND_W-1:0] step_kind_t;

  localparam step_kind_t STEP_NONE    = KIND_W'(0);
  localparam step_kind_t STEP_WALKING = KIND_W'(1);
  localparam step_kind_t STEP_RUNNING = KIND_W'(2);

endpackage

`default_nettype wire

### rtl/asd_if.sv
// ----------------------------------------------------------------------------
// asd_if
// Valid/ready channels of the step detector: sample words, result words and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface asd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [asd_pkg::AXIS_W-1:0]    accel_y;
  logic signed [asd_pkg::AXIS_W-1:0]    accel_z;
  logic        [asd_pkg::WORD_W-1:0]    timer_now;
  logic                                 link_connected;

  modport source (output valid, accel_y, accel_z, timer_now, link_connected, input ready);
  modport sink   (input valid, accel_y, accel_z, timer_now, link_connected, output ready);
endinterface

interface asd_result_if;
  logic                          valid;
  logic                          ready;
  logic [asd_pkg::KIND_W-1:0]    step_kind;
  logic                          zero_motion_report;
  logic                          idle_report;
  logic                          idle_disconnected_report;
  logic [asd_pkg::WORD_W-1:0]    step_total;
  logic                          motion_armed;

  modport source (output valid, step_kind, zero_motion_report, idle_report,
                  idle_disconnected_report, step_total, motion_armed, input ready);
  modport sink   (input valid, step_kind, zero_motion_report, idle_report,
                  idle_disconnected_report, step_total, motion_armed, output ready);
endinterface

interface asd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [asd_pkg::CFG_IDX_W-1:0]   addr;
  logic [asd_pkg::WORD_W-1:0]      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### rtl/accel_step_detector.sv
// ----------------------------------------------------------------------------
// accel_step_detector
// Threshold step detector with hysteresis, step classing and idle reports.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the result side is not stalled and
// returns one result word per sample, in order. The input stage registers
// y*y + z*z; the result stage compares it with the thresholds, updates the
// step and idle state and holds the result word, so a new sample is taken
// every cycle while results keep draining. Register writes are always
// accepted and should only be issued while the block idles.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_step_detector (
  input  wire logic      clk,
  input  wire logic      rst,
  asd_sample_if.sink     sample,
  asd_result_if.source   result,
  asd_cfg_if.sink        cfg
);

  import asd_pkg::*;

  logic [WORD_W-1:0] low_threshold_sq;
  logic [WORD_W-1:0] high_threshold_sq;
  logic [WORD_W-1:0] run_interval;
  logic [WORD_W-1:0] idle_limit;

  logic              s1_valid;
  logic [WORD_W-1:0] s1_sum;
  logic [WORD_W-1:0] s1_now;
  logic              s1_link;

  logic              armed;
  logic [WORD_W-1:0] step_counter;
  logic              had_step;
  logic [WORD_W-1:0] previous_step_time;
  logic [WORD_W-1:0] last_step_time;
  logic [WORD_W-1:0] disconnected_reference;
  logic [WORD_W-1:0] connected_reference;
  logic [WORD_W-1:0] idle_accumulator;

  logic              armed_next;
  logic [WORD_W-1:0] step_counter_next;
  logic              had_step_next;
  logic [WORD_W-1:0] previous_step_time_next;
  logic [WORD_W-1:0] last_step_time_next;
  logic [WORD_W-1:0] disconnected_reference_next;
  logic [WORD_W-1:0] connected_reference_next;
  logic [WORD_W-1:0] idle_accumulator_next;

  logic              res_valid;
  step_kind_t        res_kind;
  logic              res_zero;
  logic              res_idle;
  logic              res_idle_dis;
  logic [WORD_W-1:0] res_total;
  logic              res_armed;

  step_kind_t        kind_next;
  logic              zero_next;
  logic              idle_next;
  logic              idle_dis_next;

  logic              advance;
  logic              sample_take;
  logic [WORD_W-1:0] sq_y;
  logic [WORD_W-1:0] sq_z;
  logic              arm_hit;
  logic              armed_mid;
  logic              step_hit;
  logic [WORD_W-1:0] interval;
  logic              running;
  logic [WORD_W-1:0] idle_ref;
  logic [WORD_W-1:0] idle_sum;
  logic              idle_over;

  assign advance     = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || advance;
  assign sample_take = sample.valid && sample.ready;
  assign cfg.ready   = 1'b1;

  assign sq_y = WORD_W'($signed(sample.accel_y) * $signed(sample.accel_y));
  assign sq_z = WORD_W'($signed(sample.accel_z) * $signed(sample.accel_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold_sq  <= RST_LOW_THRESHOLD_SQ;
      high_threshold_sq <= RST_HIGH_THRESHOLD_SQ;
      run_interval      <= RST_RUN_INTERVAL;
      idle_limit        <= RST_IDLE_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_LOW_THRESHOLD_SQ:  low_threshold_sq  <= cfg.data;
        REG_HIGH_THRESHOLD_SQ: high_threshold_sq <= cfg.data;
        REG_RUN_INTERVAL:      run_interval      <= cfg.data;
        REG_IDLE_LIMIT:        idle_limit        <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_sum  <= sq_y + sq_z;
      s1_now  <= sample.timer_now;
      s1_link <= sample.link_connected;
    end
  end

  always_comb begin
    arm_hit   = (s1_sum <= low_threshold_sq) && !armed;
    armed_mid = armed || (arm_hit && (s1_sum != '0));
    step_hit  = armed_mid && (s1_sum > high_threshold_sq);
    interval  = s1_now - previous_step_time;
    running   = had_step && ($signed(interval) < $signed(run_interval));
    idle_ref  = s1_link ? connected_reference : disconnected_reference;
    idle_sum  = idle_accumulator + (s1_now - idle_ref);
    idle_over = idle_sum > idle_limit;

    armed_next                  = armed;
    step_counter_next           = step_counter;
    had_step_next               = had_step;
    previous_step_time_next     = previous_step_time;
    last_step_time_next         = last_step_time;
    disconnected_reference_next = disconnected_reference;
    connected_reference_next    = connected_reference;
    idle_accumulator_next       = idle_accumulator;
    kind_next                   = STEP_NONE;
    zero_next                   = 1'b0;
    idle_next                   = 1'b0;
    idle_dis_next               = 1'b0;

    if (s1_link) begin
      zero_next  = arm_hit && (s1_sum == '0);
      armed_next = armed_mid;
      if (step_hit) begin
        armed_next                  = 1'b0;
        step_counter_next           = step_counter + WORD_W'(1);
        last_step_time_next         = s1_now;
        disconnected_reference_next = s1_now;
        connected_reference_next    = s1_now;
        kind_next                   = running ? STEP_RUNNING : STEP_WALKING;
        had_step_next               = 1'b1;
        previous_step_time_next     = s1_now;
      end else begin
        idle_accumulator_next = idle_over ? '0 : idle_sum;
        idle_next             = idle_over;
        if (idle_over && ((last_step_time <= disconnected_reference) ||
                          (last_step_time == '0))) begin
          connected_reference_next = s1_now;
        end
      end
    end else begin
      idle_accumulator_next = idle_over ? '0 : idle_sum;
      idle_dis_next         = idle_over;
      if (idle_over) begin
        disconnected_reference_next = (last_step_time != '0) ? last_step_time : s1_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed                  <= 1'b0;
      step_counter           <= '0;
      had_step               <= 1'b0;
      previous_step_time     <= '0;
      last_step_time         <= '0;
      disconnected_reference <= '0;
      connected_reference    <= '0;
      idle_accumulator       <= '0;
    end else if (advance) begin
      armed                  <= armed_next;
      step_counter           <= step_counter_next;
      had_step               <= had_step_next;
      previous_step_time     <= previous_step_time_next;
      last_step_time         <= last_step_time_next;
      disconnected_reference <= disconnected_reference_next;
      connected_reference    <= connected_reference_next;
      idle_accumulator       <= idle_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_kind     <= kind_next;
      res_zero     <= zero_next;
      res_idle     <= idle_next;
      res_idle_dis <= idle_dis_next;
      res_total    <= step_counter_next;
      res_armed    <= armed_next;
    end
  end

  assign result.valid                    = res_valid;
  assign result.step_kind                = res_kind;
  assign result.zero_motion_report       = res_zero;
  assign result.idle_report              = res_idle;
  assign result.idle_disconnected_report = res_idle_dis;
  assign result.step_total               = res_total;
  assign result.motion_armed             = res_armed;

endmodule

`default_nettype wire

### verif/accel_step_detector_tb.sv
// ----------------------------------------------------------------------------
// accel_step_detector_tb
// Self-checking bench for the accelerometer step detector.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes comes first. It
// covers reset behaviour, axis extremes, walking and running steps, link-down
// reports and arming and stepping in one sample. Several register settings
// follow, each with a run of random samples. Every accepted sample goes
// through a local model of the detector, and each result word is compared
// field by field with the oldest outstanding expected word. Both channels idle
// and stall at random, with bursts of back-to-back traffic in between.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_step_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asd_pkg::*;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 144;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned NUM_DIRECTED    = 25;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(255);
  localparam logic [WORD_W-1:0]    MAG_MAX      = 32'h8000_0000;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [WORD_W-1:0]        timer_now;
    logic                     link_connected;
  } sample_t;

  typedef struct packed {
    step_kind_t        step_kind;
    logic              zero_motion_report;
    logic              idle_report;
    logic              idle_disconnected_report;
    logic [WORD_W-1:0] step_total;
    logic              motion_armed;
  } result_t;

  typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICTED, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [WORD_W-1:0]    reg_data;
    sample_t              smp;
    result_t              want;
  } dir_row_t;

  localparam sample_t NO_SAMPLE = '0;
  localparam result_t NO_WANT   = '0;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_TYPED, '0, '0, '{16'sd0, 16'sd0, 32'd0, 1'b1},
      '{STEP_NONE, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0}},
    '{ROW_TYPED, '0, '0, '{16'sd500, 16'sd500, 32'd10, 1'b1},
      '{STEP_NONE, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1}},
    '{ROW_TYPED, '0, '0, '{16'sh8000, 16'sh8000, 32'd50, 1'b1},
      '{STEP_WALKING, 1'b0, 1'b0, 1'b0, 32'd1, 1'b0}},
    '{ROW_TYPED, '0, '0, '{-16'sd500, 16'sd0, 32'd60, 1'b1},
      '{STEP_NONE, 1'b0, 1'b0, 1'b0, 32'd1, 1'b1}},
    '{ROW_TYPED, '0, '0, '{16'sd1000, 16'sd0, 32'd100, 1'b1},
      '{STEP_RUNNING, 1'b0, 1'b0, 1'b0, 32'd2, 1'b0}},
    '{ROW_TYPED, '0, '0, '{16'sd0, 16'sd700, 32'd150, 1'b1},
      '{STEP_NONE, 1'b0, 1'b0, 1'b0, 32'd2, 1'b1}},
    '{ROW_TYPED, '0, '0, '{16'sd0, -16'sd1000, 32'd400, 1'b1},
      '{STEP_WALKING, 1'b0, 1'b0, 1'b0, 32'd3, 1'b0}},
    '{ROW_TYPED, '0, '0, '{16'sh7FFF, 16'sh7FFF, 32'd500, 1'b0},
      '{STEP_NONE, 1'b0, 1'b0, 1'b0, 32'd3, 1'b0}},
    '{ROW_TYPED, '0, '0, '{16'shFFFF, 16'shFFFF, 32'd40000, 1'b0},
      '{STEP_NONE, 1'b0, 1'b0, 1'b1, 32'd3, 1'b0}},
    '{ROW_TYPED, '0, '0, '{16'sd0, 16'sd0, 32'd40010, 1'b1},
      '{STEP_NONE, 1'b1, 1'b1, 1'b0, 32'd3, 1'b0}},
    '{ROW_TYPED, '0, '0, '{16'sd800, 16'sd0, 32'd40020, 1'b1},
      '{STEP_NONE, 1'b0, 1'b0, 1'b0, 32'd3, 1'b0}},
    '{ROW_PREDICTED, '0, '0, '{16'sh7FFF, 16'sh7FFF, 32'd40030, 1'b1}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sd0, 16'shFFFF, 32'd40040, 1'b1}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sh8000, 16'sh7FFF, 32'd100, 1'b1}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b0}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'shFFFF, 16'sd1, 32'd0, 1'b1}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sd1000, 16'sd0, 32'h7FFF_FFFF, 1'b1}, NO_WANT},
    '{ROW_WRITE, REG_UNMAPPED, 32'd0, NO_SAMPLE, NO_WANT},
    '{ROW_WRITE, REG_LOW_THRESHOLD_SQ, 32'd700000, NO_SAMPLE, NO_WANT},
    '{ROW_WRITE, REG_HIGH_THRESHOLD_SQ, 32'd600000, NO_SAMPLE, NO_WANT},
    '{ROW_WRITE, REG_RUN_INTERVAL, 32'h8000_0000, NO_SAMPLE, NO_WANT},
    '{ROW_WRITE, REG_IDLE_LIMIT, 32'd0, NO_SAMPLE, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sd0, 16'sd800, 32'h8000_0000, 1'b1}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sd0, 16'sd0, 32'h8000_0001, 1'b1}, NO_WANT},
    '{ROW_PREDICTED, '0, '0, '{16'sh8000, 16'sh8000, 32'h8000_0010, 1'b0}, NO_WANT}
  };

  logic clk;
  logic rst = 1'b1;

  asd_sample_if sample_ch ();
  asd_result_if result_ch ();
  asd_cfg_if    cfg_ch ();

  accel_step_detector uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Detector model state and register copies
  logic [WORD_W-1:0] cfg_low_sq;
  logic [WORD_W-1:0] cfg_high_sq;
  logic [WORD_W-1:0] cfg_run_ticks;
  logic [WORD_W-1:0] cfg_idle_ticks;
  logic              det_armed;
  logic              det_had_step;
  logic [WORD_W-1:0] det_steps;
  logic [WORD_W-1:0] det_last_step;
  logic [WORD_W-1:0] det_disc_ref;
  logic [WORD_W-1:0] det_conn_ref;
  logic [WORD_W-1:0] det_idle_acc;

  result_t           step_reports_due [$];
  logic              word_typed;
  result_t           typed_report;
  int unsigned       failures;
  int unsigned       cycle_count;
  bit                burst;
  bit                link_up;
  logic [WORD_W-1:0] tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t predict_step_report(sample_t s);
    result_t     r;
    longint      ly;
    longint      lz;
    logic [31:0] mag;
    r = '0;
    r.step_kind = STEP_NONE;
    if (s.link_connected) begin
      ly = longint'($signed(s.accel_y));
      lz = longint'($signed(s.accel_z));
      mag = 32'(ly * ly + lz * lz);
      if (mag <= cfg_low_sq && !det_armed) begin
        if (mag != 32'd0) det_armed = 1'b1;
        else r.zero_motion_report = 1'b1;
      end
      if (det_armed && mag > cfg_high_sq) begin
        det_armed = 1'b0;
        det_steps = det_steps + 32'd1;
        if (det_had_step && $signed(s.timer_now - det_last_step) < $signed(cfg_run_ticks))
          r.step_kind = STEP_RUNNING;
        else
          r.step_kind = STEP_WALKING;
        det_had_step  = 1'b1;
        det_last_step = s.timer_now;
        det_disc_ref  = s.timer_now;
        det_conn_ref  = s.timer_now;
      end else begin
        det_idle_acc = det_idle_acc + (s.timer_now - det_conn_ref);
        if (det_idle_acc > cfg_idle_ticks) begin
          r.idle_report = 1'b1;
          det_idle_acc  = '0;
          if (det_last_step <= det_disc_ref || det_last_step == '0)
            det_conn_ref = s.timer_now;
        end
      end
    end else begin
      det_idle_acc = det_idle_acc + (s.timer_now - det_disc_ref);
      if (det_idle_acc > cfg_idle_ticks) begin
        r.idle_disconnected_report = 1'b1;
        det_idle_acc = '0;
        det_disc_ref = (det_last_step != '0) ? det_last_step : s.timer_now;
      end
    end
    r.step_total   = det_steps;
    r.motion_armed = det_armed;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : track_words
    result_t due;
    result_t got;
    if (rst) begin
      cfg_low_sq     = RST_LOW_THRESHOLD_SQ;
      cfg_high_sq    = RST_HIGH_THRESHOLD_SQ;
      cfg_run_ticks  = RST_RUN_INTERVAL;
      cfg_idle_ticks = RST_IDLE_LIMIT;
      det_armed      = 1'b0;
      det_had_step   = 1'b0;
      det_steps      = '0;
      det_last_step  = '0;
      det_disc_ref   = '0;
      det_conn_ref   = '0;
      det_idle_acc   = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_LOW_THRESHOLD_SQ:  cfg_low_sq     = cfg_ch.data;
          REG_HIGH_THRESHOLD_SQ: cfg_high_sq    = cfg_ch.data;
          REG_RUN_INTERVAL:      cfg_run_ticks  = cfg_ch.data;
          REG_IDLE_LIMIT:        cfg_idle_ticks = cfg_ch.data;
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        due = predict_step_report('{sample_ch.accel_y, sample_ch.accel_z,
                                    sample_ch.timer_now, sample_ch.link_connected});
        step_reports_due.push_back(word_typed ? typed_report : due);
      end
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.step_kind, result_ch.zero_motion_report, result_ch.idle_report,
                result_ch.idle_disconnected_report, result_ch.step_total,
                result_ch.motion_armed};
        if (step_reports_due.size() == 0) begin
          $display("%0t ns: result word with nothing expected, actual %0h", $time, got);
          failures++;
        end else begin
          due = step_reports_due.pop_front();
          check_field("step_kind", 32'(due.step_kind), 32'(got.step_kind));
          check_field("zero_motion_report", 32'(due.zero_motion_report),
                      32'(got.zero_motion_report));
          check_field("idle_report", 32'(due.idle_report), 32'(got.idle_report));
          check_field("idle_disconnected_report", 32'(due.idle_disconnected_report),
                      32'(got.idle_disconnected_report));
          check_field("step_total", due.step_total, got.step_total);
          check_field("motion_armed", 32'(due.motion_armed), 32'(got.motion_armed));
        end
      end
    end
  end

  function automatic logic [AXIS_W-1:0] axis_between(int lo, int hi);
    return AXIS_W'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  function automatic logic [AXIS_W-1:0] axis_extreme();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    pick = int'($urandom_range(0, 99));
    if (link_up) link_up = ($urandom_range(0, 99) >= 2);
    else         link_up = ($urandom_range(0, 99) < 15);
    if (pick < 35) begin
      s.accel_y = axis_between(-540, 540);
      s.accel_z = axis_between(-540, 540);
    end else if (pick < 70) begin
      s.accel_y = axis_between(830, 1500);
      if ($urandom_range(0, 1) == 1) s.accel_y = -s.accel_y;
      s.accel_z = axis_between(-1500, 1500);
    end else if (pick < 80) begin
      s.accel_y = axis_between(770, 826);
      s.accel_z = axis_between(-20, 20);
    end else if (pick < 85) begin
      s.accel_y = '0;
      s.accel_z = '0;
    end else if (pick < 95) begin
      s.accel_y = AXIS_W'($urandom());
      s.accel_z = AXIS_W'($urandom());
    end else begin
      s.accel_y = axis_extreme();
      s.accel_z = axis_extreme();
    end
    pick = int'($urandom_range(0, 99));
    if (pick < 80)      tick = tick + $urandom_range(0, 150);
    else if (pick < 95) tick = tick + $urandom_range(0, 3000);
    else if (pick < 99) tick = tick + $urandom_range(0, 100000);
    else                tick = $urandom();
    s.timer_now      = tick;
    s.link_connected = link_up;
    return s;
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (step_reports_due.size() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic send_sample(sample_t s, bit typed, result_t want);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.accel_y        <= s.accel_y;
    sample_ch.accel_z        <= s.accel_z;
    sample_ch.timer_now      <= s.timer_now;
    sample_ch.link_connected <= s.link_connected;
    word_typed               <= typed;
    typed_report             <= want;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  initial begin : drain_results
    int stall;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = burst ? 0 : int'($urandom_range(0, 16));
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    bit                writing;
    logic [WORD_W-1:0] lo_sq;
    logic [WORD_W-1:0] hi_sq;
    logic [WORD_W-1:0] run_ticks;
    logic [WORD_W-1:0] idle_ticks;
    sample_ch.valid          = 1'b0;
    sample_ch.accel_y        = '0;
    sample_ch.accel_z        = '0;
    sample_ch.timer_now      = '0;
    sample_ch.link_connected = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.addr              = '0;
    cfg_ch.data              = '0;
    word_typed               = 1'b0;
    typed_report             = '0;
    failures                 = 0;
    burst                    = 1'b0;
    link_up                  = 1'b1;
    tick                     = '0;
    writing                  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        if (!writing) begin
          sample_ch.valid <= 1'b0;
          wait_idle();
          writing = 1'b1;
        end
        write_register(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
      end else begin
        if (writing) begin
          cfg_ch.valid <= 1'b0;
          writing = 1'b0;
        end
        send_sample(DIRECTED[i].smp, DIRECTED[i].kind == ROW_TYPED, DIRECTED[i].want);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          lo_sq = RST_LOW_THRESHOLD_SQ;  hi_sq = RST_HIGH_THRESHOLD_SQ;
          run_ticks = RST_RUN_INTERVAL;  idle_ticks = RST_IDLE_LIMIT;
        end
        1: begin
          lo_sq = '0; hi_sq = '0; run_ticks = 32'h8000_0000; idle_ticks = '0;
        end
        2: begin
          lo_sq = MAG_MAX; hi_sq = MAG_MAX; run_ticks = 32'h7FFF_FFFF;
          idle_ticks = 32'hFFFF_FFFF;
        end
        3: begin
          lo_sq = 32'd700000; hi_sq = 32'd600000; run_ticks = '0; idle_ticks = 32'd5000;
        end
        default: begin
          lo_sq = $urandom_range(400000, 700000);
          hi_sq = $urandom_range(550000, 900000);
          run_ticks  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(20, 300);
          idle_ticks = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1000, 60000);
        end
      endcase
      sample_ch.valid <= 1'b0;
      wait_idle();
      write_register(REG_LOW_THRESHOLD_SQ, lo_sq);
      write_register(REG_HIGH_THRESHOLD_SQ, hi_sq);
      write_register(REG_RUN_INTERVAL, run_ticks);
      write_register(REG_IDLE_LIMIT, idle_ticks);
      write_register(CFG_IDX_W'($urandom_range(4, 255)), $urandom());
      cfg_ch.valid <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
        send_sample(random_sample(), 1'b0, NO_WANT);
      end
    end

    sample_ch.valid <= 1'b0;
    burst = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
